// ===== rtl/core/uart_rb_pkg.sv =====
// ----------------------------------------------------------------------------
// uart_rb_pkg
// Shared types and constants for the serial port ring buffer core: command
// and status codes, character constants and the internal stage word.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

  // default number of slots in each ring (holds one word less)
  localparam int DEPTH_DEFAULT = 256;

  // characters rewritten on receive
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // command codes
  typedef enum logic [1:0] {
    CMD_RX_EVENT = 2'd0,
    CMD_TX_READY = 2'd1,
    CMD_SW_GET   = 2'd2,
    CMD_SW_PUT   = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // which ring supplies the output byte
  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_TX   = 2'd1,
    SRC_RX   = 2'd2
  } byte_src_t;

  // control word carried from the decode stage to the output register
  typedef struct packed {
    byte_src_t src;
    status_t   status;
    logic      tx_irq;
    logic      rx_irq;
  } stage_t;

endpackage

// ===== rtl/core/uart_async_ring_buffers_core.sv =====
// ----------------------------------------------------------------------------
// uart_async_ring_buffers_core
// Transmit and receive byte rings between a serial port and software, with
// interrupt enable tracking, one command per cycle while output is taken.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command word: cmd and
//   data_in. Output channel (out_valid/out_ready) returns exactly one result
//   word per command: byte_out, status, tx_irq_enable, rx_irq_enable.
//   Each ring has DEPTH slots and holds up to DEPTH-1 bytes.
// Pipeline and throughput:
//   Accepting a command loads the decode stage and the registered ring
//   reads; the decode stage then loads the output register when that
//   register is free or taken. One command is accepted every cycle while
//   the output is taken; each command updates pointers, reads both ring
//   memories and writes at most one of them.
// Reset:
//   rst clears all pointers, both enable bits and the valid flags. Ring
//   contents are not cleared; unwritten slots may be read but not output.
// Stall:
//   When out_ready is low the output register holds, the decode stage still
//   takes one more command, and in_ready then drops until the output moves.
// ----------------------------------------------------------------------------
module uart_async_ring_buffers_core #(
  parameter int DEPTH = uart_rb_pkg::DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  uart_rb_pkg::cmd_t    cmd,
  input  logic [7:0]           data_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           byte_out,
  output uart_rb_pkg::status_t status,
  output logic                 tx_irq_enable,
  output logic                 rx_irq_enable
);
  import uart_rb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  // ring memories
  logic [7:0] tx_mem [DEPTH];
  logic [7:0] rx_mem [DEPTH];
  logic [7:0] tx_rd_data;
  logic [7:0] rx_rd_data;

  // ring pointers and enable bits
  logic [PTR_W-1:0] tx_read_ptr, tx_write_ptr, rx_read_ptr, rx_write_ptr;
  logic [PTR_W-1:0] tx_read_ptr_next, tx_write_ptr_next;
  logic [PTR_W-1:0] rx_read_ptr_next, rx_write_ptr_next;
  logic [PTR_W-1:0] tx_read_inc, tx_write_inc, rx_read_inc, rx_write_inc;
  logic             tx_irq_bit, rx_irq_bit, tx_irq_bit_next, rx_irq_bit_next;

  // stage control
  logic   in_accept;
  logic   s1_valid;
  logic   s1_advance;
  stage_t s1;
  stage_t s1_next;
  logic   tx_empty, rx_empty, tx_full, rx_full;
  logic   tx_wr_en, rx_wr_en;
  logic [7:0] rx_wr_word;

  // handshake: decode stage moves on when output register is free or taken
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign in_accept  = in_valid && in_ready;

  // wrap-around increments
  assign tx_read_inc  = (tx_read_ptr  == PTR_LAST) ? '0 : tx_read_ptr  + 1'b1;
  assign tx_write_inc = (tx_write_ptr == PTR_LAST) ? '0 : tx_write_ptr + 1'b1;
  assign rx_read_inc  = (rx_read_ptr  == PTR_LAST) ? '0 : rx_read_ptr  + 1'b1;
  assign rx_write_inc = (rx_write_ptr == PTR_LAST) ? '0 : rx_write_ptr + 1'b1;

  // occupancy flags, one slot kept free
  assign tx_empty = (tx_read_ptr == tx_write_ptr);
  assign rx_empty = (rx_read_ptr == rx_write_ptr);
  assign tx_full  = (tx_write_inc == tx_read_ptr);
  assign rx_full  = (rx_write_inc == rx_read_ptr);

  assign rx_wr_word = (data_in == CH_CR) ? CH_LF : data_in;

  // command decode
  always_comb begin
    tx_read_ptr_next  = tx_read_ptr;
    tx_write_ptr_next = tx_write_ptr;
    rx_read_ptr_next  = rx_read_ptr;
    rx_write_ptr_next = rx_write_ptr;
    tx_irq_bit_next   = tx_irq_bit;
    rx_irq_bit_next   = rx_irq_bit;
    tx_wr_en          = 1'b0;
    rx_wr_en          = 1'b0;
    s1_next.src       = SRC_NONE;
    s1_next.status    = ST_OK;
    unique case (cmd)
      CMD_RX_EVENT: begin
        if (rx_full) begin
          rx_irq_bit_next = 1'b0;
          s1_next.status  = ST_FULL;
        end else begin
          rx_wr_en          = 1'b1;
          rx_write_ptr_next = rx_write_inc;
        end
      end
      CMD_TX_READY: begin
        if (tx_empty) begin
          tx_irq_bit_next = 1'b0;
          s1_next.status  = ST_EMPTY;
        end else begin
          s1_next.src      = SRC_TX;
          tx_read_ptr_next = tx_read_inc;
          tx_irq_bit_next  = 1'b1;
        end
      end
      CMD_SW_GET: begin
        rx_irq_bit_next = 1'b1;
        if (rx_empty) begin
          s1_next.status = ST_EMPTY;
        end else begin
          s1_next.src      = SRC_RX;
          rx_read_ptr_next = rx_read_inc;
        end
      end
      CMD_SW_PUT: begin
        if (tx_full) begin
          s1_next.status = ST_FULL;
        end else begin
          tx_wr_en          = 1'b1;
          tx_write_ptr_next = tx_write_inc;
        end
        tx_irq_bit_next = 1'b1;
      end
      default: begin
        s1_next.status = ST_OK;
      end
    endcase
    s1_next.tx_irq = tx_irq_bit_next;
    s1_next.rx_irq = rx_irq_bit_next;
  end

  // pointer and enable state
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_read_ptr  <= '0;
      tx_write_ptr <= '0;
      rx_read_ptr  <= '0;
      rx_write_ptr <= '0;
      tx_irq_bit   <= 1'b0;
      rx_irq_bit   <= 1'b0;
    end else if (in_accept) begin
      tx_read_ptr  <= tx_read_ptr_next;
      tx_write_ptr <= tx_write_ptr_next;
      rx_read_ptr  <= rx_read_ptr_next;
      rx_write_ptr <= rx_write_ptr_next;
      tx_irq_bit   <= tx_irq_bit_next;
      rx_irq_bit   <= rx_irq_bit_next;
    end
  end

  // transmit ring memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (in_accept && tx_wr_en) begin
      tx_mem[tx_write_ptr] <= data_in;
    end
    if (in_accept) begin
      tx_rd_data <= tx_mem[tx_read_ptr];
    end
  end

  // receive ring memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (in_accept && rx_wr_en) begin
      rx_mem[rx_write_ptr] <= rx_wr_word;
    end
    if (in_accept) begin
      rx_rd_data <= rx_mem[rx_read_ptr];
    end
  end

  // decode stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1 <= s1_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      case (s1.src)
        SRC_TX:  byte_out <= tx_rd_data;
        SRC_RX:  byte_out <= rx_rd_data;
        default: byte_out <= 8'h00;
      endcase
      status        <= s1.status;
      tx_irq_enable <= s1.tx_irq;
      rx_irq_enable <= s1.rx_irq;
    end
  end

  // assertions
  a_get_sets_rx_irq : assert property (@(posedge clk) disable iff (rst)
    (in_accept && cmd == CMD_SW_GET) |=> rx_irq_bit)
    else $error("software get did not set receive enable");

  a_stall_only_when_full : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid))
    else $error("input stalled with a free stage");

  a_ptr_hold_when_idle : assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> ($stable(tx_read_ptr) && $stable(tx_write_ptr) &&
                    $stable(rx_read_ptr) && $stable(rx_write_ptr)))
    else $error("ring pointer moved without a command");

  a_ptr_in_range : assert property (@(posedge clk) disable iff (rst)
    (tx_read_ptr <= PTR_LAST) && (tx_write_ptr <= PTR_LAST) &&
    (rx_read_ptr <= PTR_LAST) && (rx_write_ptr <= PTR_LAST))
    else $error("ring pointer out of range");

endmodule
